### rtl/stream_find_replace_assert.svh
// Assertion macros for the stream find/replace block.
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3
  } cfg_reg_e;

  // One pending output item.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  // Per-cycle control of one window cell.
  typedef struct packed {
    logic we;
    logic shift;
  } win_ctrl_t;

  // Per-cycle control of one output queue cell.
  typedef struct packed {
    logic load;
    logic shift;
  } out_ctrl_t;

endpackage

### rtl/sfr_win_cell.sv
module sfr_win_cell (
  input  logic              clk_i,
  input  sfr_pkg::win_ctrl_t ctrl_i,
  input  logic [7:0]        in_byte_i,
  input  logic [7:0]        nbr_byte_i,
  input  logic [7:0]        pat_byte_i,
  output logic [7:0]        cur_byte_o,
  output logic              eq_o
);
  import sfr_pkg::*;

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // The byte this cell holds once the incoming item is written in.
  assign cur_byte_o = ctrl_i.we ? in_byte_i : byte_q;
  assign eq_o       = (cur_byte_o == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = nbr_byte_i;
    end else if (ctrl_i.we) begin
      byte_d = in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

### rtl/sfr_out_cell.sv
module sfr_out_cell (
  input  logic               clk_i,
  input  sfr_pkg::out_ctrl_t ctrl_i,
  input  sfr_pkg::item_t     new_item_i,
  input  sfr_pkg::item_t     nbr_item_i,
  output sfr_pkg::item_t     item_o
);
  import sfr_pkg::*;

  item_t item_q;
  item_t item_d;

  assign item_o = item_q;

  always_comb begin
    item_d = item_q;
    if (ctrl_i.load) begin
      item_d = new_item_i;
    end else if (ctrl_i.shift) begin
      item_d = nbr_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

### rtl/stream_find_replace.sv
// Output: the results of an accepted item are registered in the output cell chain.
// Throughput: one item per cycle while each item yields at most one result and the
//   output is not stalled; an item that yields n results (up to the larger of the
//   two maximum lengths) holds off the input until at most one result is queued.
// Reset: window and output chain empty, pattern length 1, replacement length 0,
//   pattern and replacement bytes zero.
module stream_find_replace #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tlast,   // end_of_stream
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] out_byte
  output logic [0:0]                   m_axis_tuser,   // [0] byte_present
  output logic                         m_axis_tlast    // out_last
);
  import sfr_pkg::*;

  localparam int unsigned NI = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                               : MAX_REPLACEMENT;
  localparam int unsigned QD = NI + 1;
  localparam int unsigned CW = $clog2(QD + 1);
  localparam int unsigned WW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RW = $clog2(MAX_REPLACEMENT + 1);

  // Configuration registers
  logic [CfgDataW-1:0] pat_q, pat_d;
  logic [CfgDataW-1:0] rep_q, rep_d;
  logic [WW-1:0]       plen_q, plen_d;
  logic [RW-1:0]       rlen_q, rlen_d;
  logic [3:0]          len_wr;
  logic                plen_wr;

  // Window and output queue control state
  logic [WW-1:0] wc_q, wc_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic       acc, pop, full, match, marker, base;
  logic [CW-1:0] n;

  logic [7:0]          win_cur [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] win_eq;
  logic [MAX_PATTERN-1:0] win_hit;
  win_ctrl_t           win_ctrl [MAX_PATTERN];

  logic [7:0] win_b  [QD];
  logic [7:0] rep_b  [QD];
  item_t      items  [QD];
  item_t      q_item [QD];
  out_ctrl_t  q_ctrl [QD];

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign len_wr      = cfg_data_i[3:0];

  always_comb begin
    pat_d   = pat_q;
    rep_d   = rep_q;
    plen_d  = plen_q;
    rlen_d  = rlen_q;
    plen_wr = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_BYTES: pat_d = cfg_data_i;
        REG_PATTERN_LENGTH: begin
          plen_wr = 1'b1;
          if (len_wr == 4'd0) begin
            plen_d = WW'(1);
          end else if (len_wr > 4'(MAX_PATTERN)) begin
            plen_d = WW'(MAX_PATTERN);
          end else begin
            plen_d = WW'(len_wr);
          end
        end
        REG_REPLACEMENT_BYTES: rep_d = cfg_data_i;
        REG_REPLACEMENT_LENGTH: begin
          if (len_wr > 4'(MAX_REPLACEMENT)) begin
            rlen_d = RW'(MAX_REPLACEMENT);
          end else begin
            rlen_d = RW'(len_wr);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Window cell row
  // ---------------------------------------------------------------------------
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign full = ((wc_q + WW'(1)) == plen_q);

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    logic [7:0] nbr;
    if (i < MAX_PATTERN - 1) begin : g_mid
      assign nbr = win_cur[i+1];
    end else begin : g_end
      assign nbr = 8'h00;
    end

    assign win_ctrl[i].we    = acc && (wc_q == WW'(i));
    assign win_ctrl[i].shift = acc && full && !match;
    // cells past the pattern length do not take part in the compare
    assign win_hit[i]        = win_eq[i] || (WW'(i) >= plen_q);

    sfr_win_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (win_ctrl[i]),
      .in_byte_i  (s_axis_tdata),
      .nbr_byte_i (nbr),
      .pat_byte_i (pat_q[8*i +: 8]),
      .cur_byte_o (win_cur[i]),
      .eq_o       (win_eq[i])
    );
  end

  assign match  = full && (&win_hit);
  assign marker = match && s_axis_tlast && (rlen_q == RW'(0));

  // Number of results this item yields
  always_comb begin
    if (match) begin
      n = marker ? CW'(1) : CW'(rlen_q);
    end else if (full) begin
      n = s_axis_tlast ? CW'(plen_q) : CW'(1);
    end else begin
      n = s_axis_tlast ? (CW'(wc_q) + CW'(1)) : CW'(0);
    end
  end

  always_comb begin
    wc_d = wc_q;
    if (plen_wr) begin
      wc_d = '0;
    end else if (acc) begin
      if (s_axis_tlast || match) begin
        wc_d = '0;
      end else if (!full) begin
        wc_d = wc_q + WW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Candidate results, padded to the queue depth
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < QD; k++) begin : g_item
    if (k < MAX_PATTERN) begin : g_w
      assign win_b[k] = win_cur[k];
    end else begin : g_wz
      assign win_b[k] = 8'h00;
    end
    if (k < MAX_REPLACEMENT) begin : g_r
      assign rep_b[k] = rep_q[8*k +: 8];
    end else begin : g_rz
      assign rep_b[k] = 8'h00;
    end

    always_comb begin
      items[k].data    = match ? rep_b[k] : win_b[k];
      items[k].present = 1'b1;
      if (marker) begin
        items[k].data    = 8'h00;
        items[k].present = 1'b0;
      end
      items[k].last = s_axis_tlast && (CW'(k) == (n - CW'(1)));
    end
  end

  // ---------------------------------------------------------------------------
  // Output cell chain: head at cell 0, drains, while the receiver is ready, one item per cycle
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = (cnt_q != CW'(0));
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= CW'(1));
  // new results land right behind whatever stays in the chain
  assign base          = (cnt_q == CW'(1)) && !pop;

  for (genvar j = 0; j < QD; j++) begin : g_out
    item_t nbr;
    item_t nitem;
    if (j < QD - 1) begin : g_mid
      assign nbr = q_item[j+1];
    end else begin : g_end
      assign nbr = '0;
    end
    if (j > 0) begin : g_sel
      assign nitem = base ? items[j-1] : items[j];
    end else begin : g_head
      assign nitem = items[j];
    end

    assign q_ctrl[j].load  = acc && (CW'(j) >= CW'(base))
                             && (CW'(j) < (CW'(base) + n));
    assign q_ctrl[j].shift = pop;

    sfr_out_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (q_ctrl[j]),
      .new_item_i (nitem),
      .nbr_item_i (nbr),
      .item_o     (q_item[j])
    );
  end

  always_comb begin
    cnt_d = cnt_q - (pop ? CW'(1) : CW'(0));
    if (acc) begin
      cnt_d = cnt_d + n;
    end
  end

  assign m_axis_tdata    = q_item[0].data;
  assign m_axis_tuser[0] = q_item[0].present;
  assign m_axis_tlast    = q_item[0].last;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= WW'(1);
      rlen_q <= '0;
      wc_q   <= '0;
      cnt_q  <= '0;
    end else begin
      pat_q  <= pat_d;
      rep_q  <= rep_d;
      plen_q <= plen_d;
      rlen_q <= rlen_d;
      wc_q   <= wc_d;
      cnt_q  <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "stream_find_replace_assert.svh"

  `SFR_ASSERT_NOW(a_win_bound, 1'b1, wc_q < plen_q, "window count reached pattern length")
  `SFR_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= CW'(QD), "output chain overflow")
  `SFR_ASSERT_NEXT(a_end_clears, acc && s_axis_tlast, wc_q == '0, "window not empty after end")
  `SFR_ASSERT_NEXT(a_end_emits, acc && s_axis_tlast, m_axis_tvalid, "end item gave no result")

endmodule

### tb/find_replace_checker.sv
`timescale 1ns / 1ps
module find_replace_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [7:0]                   m_tdata_i,
  input  logic [0:0]                   m_tuser_i,
  input  logic                         m_tlast_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o
);
  import sfr_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned MAX_REPLACE  = 8;
  localparam int unsigned REPORT_LINES = 40;

  logic [63:0] pattern_q;
  logic [3:0]  pattern_len_q;
  logic [63:0] replace_q;
  logic [3:0]  replace_len_q;
  logic [7:0]  window_q [WINDOW_DEPTH];
  int unsigned held;
  item_t       expected_out_q [$];
  int unsigned mismatches = 0;
  int unsigned queued = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = queued;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= REPORT_LINES) begin
      $display("%0d ns: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
    end
  endtask

  // Work out the output items that one accepted input byte causes.
  task automatic predict_item(input logic [7:0] data, input logic last);
    item_t       produced [$];
    item_t       tail;
    int unsigned plen;
    int unsigned rlen;
    int unsigned i;
    logic        hit;
    plen = (pattern_len_q == 4'd0) ? 1 :
           (pattern_len_q > WINDOW_DEPTH) ? WINDOW_DEPTH : pattern_len_q;
    rlen = (replace_len_q > MAX_REPLACE) ? MAX_REPLACE : replace_len_q;
    if (held >= plen) held = 0;
    window_q[held] = data;
    held++;
    if (held == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (window_q[i] != pattern_q[i*8 +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) produced.push_back({replace_q[i*8 +: 8], 1'b1, 1'b0});
        held = 0;
      end else begin
        // emit the oldest byte and slide the window
        produced.push_back({window_q[0], 1'b1, 1'b0});
        for (i = 1; i < WINDOW_DEPTH; i++) window_q[i-1] = window_q[i];
        held--;
      end
    end
    if (last) begin
      for (i = 0; i < held; i++) produced.push_back({window_q[i], 1'b1, 1'b0});
      held = 0;
      // nothing left to carry the end: send a bare marker
      if (produced.size() == 0) produced.push_back({8'h00, 1'b0, 1'b0});
      tail = produced.pop_back();
      tail.last = 1'b1;
      produced.push_back(tail);
    end
    foreach (produced[j]) expected_out_q.push_back(produced[j]);
  endtask

  always @(posedge clk_i) begin
    item_t want;
    if (!rst_ni) begin
      pattern_q     = '0;
      pattern_len_q = 4'd1;
      replace_q     = '0;
      replace_len_q = 4'd0;
      foreach (window_q[k]) window_q[k] = 8'h00;
      held = 0;
      expected_out_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch("unexpected output item", m_tdata_i, 8'h00);
        end else begin
          want = expected_out_q.pop_front();
          if (m_tdata_i !== want.data) report_mismatch("out_byte", m_tdata_i, want.data);
          if (m_tuser_i[0] !== want.present) begin
            report_mismatch("byte_present", {7'd0, m_tuser_i[0]}, {7'd0, want.present});
          end
          if (m_tlast_i !== want.last) begin
            report_mismatch("out_last", {7'd0, m_tlast_i}, {7'd0, want.last});
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PATTERN_BYTES: pattern_q = cfg_data_i;
          REG_PATTERN_LENGTH: begin
            pattern_len_q = cfg_data_i[3:0];
            held = 0;
          end
          REG_REPLACEMENT_BYTES: replace_q = cfg_data_i;
          REG_REPLACEMENT_LENGTH: replace_len_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) predict_item(s_tdata_i, s_tlast_i);
    end
    queued = expected_out_q.size();
  end

endmodule

### tb/tb_stream_find_replace.sv
`timescale 1ns / 1ps
module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam int unsigned LIMIT_CYCLES     = 300000;
  localparam int unsigned DRAIN_CYCLES     = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS     = 500;
  localparam int unsigned HOLD_AFTER_ITEMS = 200;
  localparam logic [CfgIdxW-1:0] IDX_PAST_LIST = 8'd4;
  localparam logic [CfgIdxW-1:0] IDX_TOP       = 8'hFF;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;
  logic [0:0]          m_tuser;
  logic                m_tlast;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 3;
  logic        hold_req = 1'b0;
  logic [63:0] cur_pattern;
  int unsigned cur_plen;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stream_find_replace u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  find_replace_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tlast_i        (s_tlast),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .m_tlast_i        (m_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_stream_find_replace failed");
      $finish;
    end
  end

  // Receiver: stall modes held for runs of random length, plus one long hold.
  initial begin
    int unsigned run_left;
    int unsigned mode;
    logic        hold_taken;
    run_left = 0;
    mode = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        hold_taken = 1'b1;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 3);
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = $urandom_range(0, 1);
          2: m_tready = ($urandom_range(0, 7) != 0);
          default: m_tready = (run_left % 5 != 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one item; bursts of random length with random gaps between them.
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(0, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 32);
    end
    s_tvalid = 1'b1;
    s_tdata  = data;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic pick_setting();
    logic [7:0]  letter_a;
    logic [7:0]  letter_b;
    logic [63:0] len_word;
    int unsigned i;
    int unsigned rlen;
    letter_a = $urandom_range(0, 255);
    letter_b = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: cur_pattern = {$urandom, $urandom};
      1: begin
        for (i = 0; i < 8; i++) cur_pattern[i*8 +: 8] = $urandom_range(0, 1) ? letter_a : letter_b;
      end
      2: cur_pattern = $urandom_range(0, 1) ? '1 : '0;
      default: begin
        for (i = 0; i < 8; i++) cur_pattern[i*8 +: 8] = letter_a ^ 8'($urandom_range(0, 3));
      end
    endcase
    cur_plen = $urandom_range(1, 8);
    len_word = 64'(cur_plen);
    case ($urandom_range(0, 9))
      0: begin
        len_word = 64'd0;
        cur_plen = 1;
      end
      1: begin
        len_word = 64'($urandom_range(9, 15));
        cur_plen = 8;
      end
      2: len_word = {$urandom, $urandom} & ~64'hF | len_word;
      default: ;
    endcase
    write_reg(REG_PATTERN_BYTES, cur_pattern);
    write_reg(REG_PATTERN_LENGTH, len_word);
    case ($urandom_range(0, 3))
      0: write_reg(REG_REPLACEMENT_BYTES, '1);
      1: write_reg(REG_REPLACEMENT_BYTES, '0);
      default: write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    endcase
    rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
  endtask

  // Text built from whole and partial copies of the pattern, single pattern bytes and random bytes.
  task automatic send_stream(input int unsigned target, input logic close);
    logic [7:0]  text [$];
    int unsigned r;
    int unsigned n;
    int unsigned i;
    int unsigned k;
    while (text.size() < target) begin
      r = $urandom_range(0, 99);
      n = (r < 25) ? cur_plen : (r < 40) ? $urandom_range(1, cur_plen) : 0;
      if (n > 0) begin
        for (i = 0; i < n; i++) text.push_back(cur_pattern[i*8 +: 8]);
      end else if (r < 70) begin
        k = $urandom_range(0, cur_plen - 1);
        text.push_back(cur_pattern[k*8 +: 8]);
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (i = 0; i < text.size(); i++) send_byte(text[i], close && (i == text.size() - 1));
    items_sent += text.size();
  endtask

  initial begin
    int unsigned streams;
    int unsigned s;
    logic        hold_done;
    hold_done = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: pattern is one zero byte, matches are deleted.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_results();

    // Two-byte pattern expanding to the longest replacement.
    write_reg(REG_PATTERN_BYTES, 64'h4241);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_REPLACEMENT_BYTES, 64'hFF00_FF00_FF00_FF00);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    drain_results();

    // Oversized pattern length saturates; deleting match on the end gives a marker.
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // Leave bytes in the window, then rewrite the length to drop them.
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    drain_results();
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
    write_reg(IDX_PAST_LIST, '1);
    write_reg(IDX_TOP, '1);
    send_byte(8'h03, 1'b1);
    send_byte(8'hFF, 1'b1);

    while (items_sent < RANDOM_ITEMS) begin
      drain_results();
      pick_setting();
      streams = $urandom_range(2, 6);
      for (s = 0; s < streams; s++) begin
        if (!hold_done && items_sent >= HOLD_AFTER_ITEMS) begin
          // keep offering items while the receiver holds off
          hold_req = 1'b1;
          hold_done = 1'b1;
          send_stream(80, 1'b1);
        end
        send_stream($urandom_range(1, 40), (s < streams - 1) || ($urandom_range(0, 4) != 0));
      end
    end
    drain_results();

    if (mismatch_count == 0) begin
      $display("tb_stream_find_replace passed");
    end else begin
      $display("tb_stream_find_replace failed");
    end
    $finish;
  end

endmodule

### stream_find_replace.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_win_cell.sv
rtl/sfr_out_cell.sv
rtl/stream_find_replace.sv
tb/find_replace_checker.sv
tb/tb_stream_find_replace.sv
